// ----- src/tisp_pkg.sv -----
// Shared constants, types and helpers for the tape image to SRAM image port.
package tisp_pkg;

  localparam int BODY_DEPTH          = 65536;
  localparam int SOURCE_HEADER_BYTES = 128;
  localparam int IMAGE_HEADER_BYTES  = 9;

  localparam int BODY_AW = $clog2(BODY_DEPTH);
  localparam int LC_W    = $clog2(SOURCE_HEADER_BYTES + BODY_DEPTH + 1);
  localparam int POS_W   = 17;
  localparam int HDR_IW  = $clog2(IMAGE_HEADER_BYTES);

  // file header offsets of the size, load and exec words
  localparam int OFS_SIZE = 18;
  localparam int OFS_LOAD = 20;
  localparam int OFS_EXEC = 22;

  // request kinds
  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_SEEK  = 3'd3;
  localparam logic [2:0] REQ_SKIP  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SEEK_OOR = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_NOLOAD   = 2'd3;

  typedef logic [7:0] byte_t;
  typedef logic [7:0][7:0] hdr8_t;  // image header bytes 0..7

  function automatic logic [3:0] ones8(input byte_t v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

// ----- src/tape_image_to_sram_image_port_top.sv -----
// Top level of the tape image to SRAM image port.
//
// Input channel (in_*): one request per transfer. in_tuser carries the request
// kind (load byte, read, write, seek, skip), in_tlast marks the final byte of
// a loaded file, in_tdata carries the data byte and the seek position.
// Output channel (out_*): exactly one result per request, in request order:
// read byte, status, cursor after the step and image size.
//
// Timing: every result is registered. A read that lands in the body goes
// through the body RAM, whose read is registered, so it passes through
// state S_RD first and no new request is taken until its result is loaded.
// The final load byte likewise passes through state S_FIN to build the
// image header and its check byte. For all other requests the result shows
// up the cycle after acceptance, at one per cycle while out_tready is high.
// A finished result waits in the output register; the next request is taken
// in the same cycle the receiver takes the waiting result. While out_tready is
// low with a result pending, in_tready stays low.
// Reset clears the control state: nothing loaded, cursor 0, image size 9.
// The body RAM is not cleared; body entries read before written are undefined.
module tape_image_to_sram_image_port_top (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] data_byte, [24:8] seek_pos, [31:25] zero
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  input  logic        in_tlast,   // load_last
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] read_byte, [24:8] position,
                                  // [41:25] image_size, [47:42] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import tisp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;  // body RAM read in flight
  localparam logic [1:0] S_FIN  = 2'd2;  // header build after last load byte

  // control
  logic [1:0]       state_r, state_nxt;
  logic             loaded_r, loaded_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LC_W-1:0]  lc_r, lc_nxt;
  logic [POS_W-1:0] cursor_r, cursor_nxt;
  logic [POS_W-1:0] total_r, total_nxt;
  logic [15:0]      load_w_r, load_w_nxt;
  logic [15:0]      exec_w_r, exec_w_nxt;
  logic [15:0]      sum_r, sum_nxt;
  byte_t            hdr_r [IMAGE_HEADER_BYTES];
  byte_t            hdr_nxt [IMAGE_HEADER_BYTES];

  // output register
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_rb_r, out_rb_nxt;
  logic [1:0]       out_st_r, out_st_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [POS_W-1:0] out_size_r, out_size_nxt;

  // body RAM
  logic               mem_we, mem_re;
  logic [BODY_AW-1:0] mem_waddr, mem_raddr;
  byte_t              mem_wdata, mem_rdata;

  // header check byte
  hdr8_t csum_in;
  byte_t csum;

  // request fields
  byte_t            req_b;
  logic [POS_W-1:0] req_sp;
  logic             acc;

  // scratch
  logic             out_ld;
  byte_t            res_rb;
  logic [1:0]       res_st;
  logic [LC_W-1:0]  off;
  logic             ovf;
  logic [BODY_AW-1:0] bi;
  logic [15:0]      bsize;
  logic [POS_W-1:0] cur_inc;
  logic [POS_W-1:0] cur_adv;
  logic [BODY_AW-1:0] cur_bi;

  assign req_b  = in_tdata[7:0];
  assign req_sp = in_tdata[8 +: POS_W];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {6'd0, out_size_r, out_pos_r, out_rb_r};

  // cursor step with wrap at image end
  assign cur_inc = cursor_r + POS_W'(1);
  assign cur_adv = (cur_inc >= total_r) ? '0 : cur_inc;
  assign cur_bi  = BODY_AW'(cursor_r - POS_W'(IMAGE_HEADER_BYTES));

  assign csum_in = {sum_r[15:8], sum_r[7:0], exec_w_r[15:8], exec_w_r[7:0],
                    load_w_r[15:8], load_w_r[7:0], hdr_r[1], hdr_r[0]};

  tisp_hdr_csum u_csum (
    .hdr  (csum_in),
    .csum (csum)
  );

  tisp_body_ram u_body (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    ovf_nxt    = ovf_r;
    lc_nxt     = lc_r;
    cursor_nxt = cursor_r;
    total_nxt  = total_r;
    load_w_nxt = load_w_r;
    exec_w_nxt = exec_w_r;
    sum_nxt    = sum_r;
    for (int i = 0; i < IMAGE_HEADER_BYTES; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    mem_we    = 1'b0;
    mem_waddr = cur_bi;
    mem_wdata = req_b;
    mem_re    = 1'b0;
    mem_raddr = cur_bi;
    out_ld    = 1'b0;
    res_rb    = '0;
    res_st    = ST_OK;
    off       = '0;
    ovf       = 1'b0;
    bi        = '0;
    bsize     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_ld = 1'b1;
          if (in_tuser == REQ_LOAD) begin
            // a new file after a finished load starts from a clean slate
            if (loaded_r) begin
              lc_nxt     = '0;
              load_w_nxt = '0;
              exec_w_nxt = '0;
              sum_nxt    = '0;
              cursor_nxt = '0;
              total_nxt  = POS_W'(IMAGE_HEADER_BYTES);
              loaded_nxt = 1'b0;
              for (int i = 0; i < IMAGE_HEADER_BYTES; i++) begin
                hdr_nxt[i] = '0;
              end
            end
            off = lc_nxt;
            ovf = off >= LC_W'(SOURCE_HEADER_BYTES + BODY_DEPTH);
            if (!ovf) begin
              if (off == LC_W'(OFS_SIZE))         hdr_nxt[0] = req_b;
              else if (off == LC_W'(OFS_SIZE + 1)) hdr_nxt[1] = req_b;
              else if (off == LC_W'(OFS_LOAD))     load_w_nxt[7:0] = req_b;
              else if (off == LC_W'(OFS_LOAD + 1)) load_w_nxt[15:8] = req_b;
              else if (off == LC_W'(OFS_EXEC))     exec_w_nxt[7:0] = req_b;
              else if (off == LC_W'(OFS_EXEC + 1)) exec_w_nxt[15:8] = req_b;
              if (off >= LC_W'(SOURCE_HEADER_BYTES)) begin
                bi        = BODY_AW'(off - LC_W'(SOURCE_HEADER_BYTES));
                bsize     = {hdr_nxt[1], hdr_nxt[0]};
                mem_we    = 1'b1;
                mem_waddr = bi;
                if (17'(bi) < 17'(bsize)) begin
                  sum_nxt = sum_nxt + 16'(ones8(req_b));
                end
              end
              lc_nxt = off + LC_W'(1);
            end
            res_st = ovf ? ST_NOLOAD : ST_OK;
            if (in_tlast) begin
              out_ld    = 1'b0;
              ovf_nxt   = ovf;
              state_nxt = S_FIN;
            end
          end else if (in_tuser <= REQ_SKIP && !loaded_r) begin
            res_st = ST_NOLOAD;
          end else if (in_tuser == REQ_READ) begin
            cursor_nxt = cur_adv;
            if (cursor_r < POS_W'(IMAGE_HEADER_BYTES)) begin
              res_rb = hdr_r[cursor_r[HDR_IW-1:0]];
            end else begin
              mem_re    = 1'b1;
              out_ld    = 1'b0;
              state_nxt = S_RD;
            end
          end else if (in_tuser == REQ_WRITE) begin
            cursor_nxt = cur_adv;
            if (cursor_r < POS_W'(IMAGE_HEADER_BYTES)) begin
              hdr_nxt[cursor_r[HDR_IW-1:0]] = req_b;
            end else begin
              mem_we = 1'b1;
            end
          end else if (in_tuser == REQ_SEEK) begin
            if (req_sp >= total_r) res_st = ST_SEEK_OOR;
            else cursor_nxt = req_sp;
          end else if (in_tuser == REQ_SKIP) begin
            cursor_nxt = cur_adv;
          end
        end
      end
      S_RD: begin
        out_ld    = 1'b1;
        res_rb    = mem_rdata;
        state_nxt = S_IDLE;
      end
      S_FIN: begin
        out_ld     = 1'b1;
        cursor_nxt = '0;
        loaded_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (lc_r < LC_W'(SOURCE_HEADER_BYTES)) begin
          // file ended inside its header: empty image
          load_w_nxt = '0;
          exec_w_nxt = '0;
          sum_nxt    = '0;
          total_nxt  = POS_W'(IMAGE_HEADER_BYTES);
          for (int i = 0; i < IMAGE_HEADER_BYTES; i++) begin
            hdr_nxt[i] = '0;
          end
          res_st = ST_SHORT;
        end else begin
          hdr_nxt[2] = load_w_r[7:0];
          hdr_nxt[3] = load_w_r[15:8];
          hdr_nxt[4] = exec_w_r[7:0];
          hdr_nxt[5] = exec_w_r[15:8];
          hdr_nxt[6] = sum_r[7:0];
          hdr_nxt[7] = sum_r[15:8];
          hdr_nxt[8] = csum;
          total_nxt  = POS_W'(IMAGE_HEADER_BYTES) + POS_W'({hdr_r[1], hdr_r[0]});
          res_st     = ovf_r ? ST_NOLOAD : ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_ld ? 1'b1 : (out_valid_r && !out_tready);
    out_rb_nxt    = out_ld ? res_rb     : out_rb_r;
    out_st_nxt    = out_ld ? res_st     : out_st_r;
    out_pos_nxt   = out_ld ? cursor_nxt : out_pos_r;
    out_size_nxt  = out_ld ? total_nxt  : out_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= 1'b0;
      ovf_r       <= 1'b0;
      lc_r        <= '0;
      cursor_r    <= '0;
      total_r     <= POS_W'(IMAGE_HEADER_BYTES);
      load_w_r    <= '0;
      exec_w_r    <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < IMAGE_HEADER_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      ovf_r       <= ovf_nxt;
      lc_r        <= lc_nxt;
      cursor_r    <= cursor_nxt;
      total_r     <= total_nxt;
      load_w_r    <= load_w_nxt;
      exec_w_r    <= exec_w_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < IMAGE_HEADER_BYTES; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rb_r   <= out_rb_nxt;
    out_st_r   <= out_st_nxt;
    out_pos_r  <= out_pos_nxt;
    out_size_r <= out_size_nxt;
  end

endmodule

// ----- src/tisp_body_ram.sv -----
// Body byte store: one write port, one registered read port.
module tisp_body_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [tisp_pkg::BODY_AW-1:0] waddr,
  input  tisp_pkg::byte_t             wdata,
  input  logic                        re,
  input  logic [tisp_pkg::BODY_AW-1:0] raddr,
  output tisp_pkg::byte_t             rdata
);
  import tisp_pkg::*;

  byte_t mem [BODY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/tisp_hdr_csum.sv -----
// Header check byte: low byte of the one-bit count over header bytes 0..7.
module tisp_hdr_csum (
  input  tisp_pkg::hdr8_t hdr,
  output tisp_pkg::byte_t csum
);
  import tisp_pkg::*;

  logic [6:0] total;

  always_comb begin
    total = '0;
    for (int i = 0; i < 8; i++) begin
      total = total + 7'(ones8(hdr[i]));
    end
    csum = 8'(total);
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the tape image to SRAM image port: request stream, predictor, result check.
module tb_top;
  import tisp_pkg::*;

  // One request as it travels on the input channel.
  typedef struct packed {
    logic [2:0]  kind;
    byte_t       data;
    logic        last;
    logic [16:0] seek_pos;
  } request_t;

  // One result as it comes back on the output channel.
  typedef struct packed {
    byte_t       read_byte;
    logic [1:0]  status;
    logic [16:0] position;
    logic [16:0] image_size;
  } image_result_t;

  // A queued request together with the result the predictor gave for it.
  typedef struct packed {
    request_t      req;
    image_result_t res;
  } port_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [7:0] data_byte, [24:8] seek_pos, [31:25] zero
  logic [2:0]  in_tuser = '0;   // [2:0] req_type
  logic        in_tlast = 1'b0; // load_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [7:0] read_byte, [24:8] position, [41:25] image_size
  logic [1:0]  out_tuser;       // [1:0] status

  tape_image_to_sram_image_port_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Image predictor. Runs as requests are queued, so the stimulus can steer
  // around body entries that were never written.
  // --------------------------------------------------------------------------
  int          img_load_count;
  byte_t       img_hdr [IMAGE_HEADER_BYTES];
  logic [15:0] img_load_word;
  logic [15:0] img_exec_word;
  logic [15:0] img_body_sum;
  int          img_cursor;
  int          img_total;
  bit          img_loaded;
  byte_t       body_mem [BODY_DEPTH];
  bit          body_written [BODY_DEPTH];

  function automatic void clear_image();
    img_load_count = 0;
    foreach (img_hdr[i]) img_hdr[i] = '0;
    img_load_word = '0;
    img_exec_word = '0;
    img_body_sum  = '0;
    img_cursor    = 0;
    img_total     = IMAGE_HEADER_BYTES;
    img_loaded    = 1'b0;
  endfunction

  // cursor wraps to the image start past its last byte
  function automatic void advance_cursor();
    img_cursor++;
    if (img_cursor >= img_total) img_cursor = 0;
  endfunction

  function automatic image_result_t step_image_port(request_t r);
    image_result_t res;
    int off;
    int ones;
    res = '0;
    res.status = ST_OK;
    if (r.kind == REQ_LOAD) begin
      // first byte of a new file drops the previous image
      if (img_loaded) clear_image();
      off = img_load_count;
      if (off >= SOURCE_HEADER_BYTES + BODY_DEPTH) begin
        res.status = ST_NOLOAD;  // overflow: byte dropped
      end else begin
        case (off)
          OFS_SIZE:     img_hdr[0] = r.data;
          OFS_SIZE + 1: img_hdr[1] = r.data;
          OFS_LOAD:     img_load_word[7:0] = r.data;
          OFS_LOAD + 1: img_load_word[15:8] = r.data;
          OFS_EXEC:     img_exec_word[7:0] = r.data;
          OFS_EXEC + 1: img_exec_word[15:8] = r.data;
          default: ;
        endcase
        if (off >= SOURCE_HEADER_BYTES) begin
          body_mem[off - SOURCE_HEADER_BYTES]     = r.data;
          body_written[off - SOURCE_HEADER_BYTES] = 1'b1;
          if (off - SOURCE_HEADER_BYTES < int'({img_hdr[1], img_hdr[0]}))
            img_body_sum = img_body_sum + 16'($countones(r.data));
        end
        img_load_count = off + 1;
      end
      if (r.last) begin
        if (img_load_count < SOURCE_HEADER_BYTES) begin
          // file ended inside its header
          foreach (img_hdr[i]) img_hdr[i] = '0;
          img_load_word = '0;
          img_exec_word = '0;
          img_body_sum  = '0;
          img_total     = IMAGE_HEADER_BYTES;
          res.status    = ST_SHORT;
        end else begin
          img_hdr[2] = img_load_word[7:0];
          img_hdr[3] = img_load_word[15:8];
          img_hdr[4] = img_exec_word[7:0];
          img_hdr[5] = img_exec_word[15:8];
          img_hdr[6] = img_body_sum[7:0];
          img_hdr[7] = img_body_sum[15:8];
          ones = 0;
          for (int i = 0; i < 8; i++) ones += $countones(img_hdr[i]);
          img_hdr[8] = ones[7:0];
          img_total  = IMAGE_HEADER_BYTES + int'({img_hdr[1], img_hdr[0]});
        end
        img_cursor = 0;
        img_loaded = 1'b1;
      end
    end else if (r.kind <= REQ_SKIP && !img_loaded) begin
      res.status = ST_NOLOAD;
    end else begin
      case (r.kind)
        REQ_READ: begin
          if (img_cursor < IMAGE_HEADER_BYTES) res.read_byte = img_hdr[img_cursor];
          else res.read_byte = body_mem[img_cursor - IMAGE_HEADER_BYTES];
          advance_cursor();
        end
        REQ_WRITE: begin
          if (img_cursor < IMAGE_HEADER_BYTES) begin
            img_hdr[img_cursor] = r.data;
          end else begin
            body_mem[img_cursor - IMAGE_HEADER_BYTES]     = r.data;
            body_written[img_cursor - IMAGE_HEADER_BYTES] = 1'b1;
          end
          advance_cursor();
        end
        REQ_SEEK: begin
          if (r.seek_pos >= img_total) res.status = ST_SEEK_OOR;
          else img_cursor = int'(r.seek_pos);
        end
        REQ_SKIP: advance_cursor();
        default: ;  // unknown kinds are a no-op with status ok
      endcase
    end
    res.position   = img_cursor[16:0];
    res.image_size = img_total[16:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  port_entry_t   pending_requests[$];  // built up front, drained by the driver
  image_result_t due_results[$];       // results owed for accepted requests

  task automatic add_req(logic [2:0] kind, byte_t data, logic last, logic [16:0] pos);
    port_entry_t e;
    e.req.kind     = kind;
    e.req.data     = data;
    e.req.last     = last;
    e.req.seek_pos = pos;
    // a body entry never written has no defined value: write it instead
    if (kind == REQ_READ && img_loaded && img_cursor >= IMAGE_HEADER_BYTES &&
        !body_written[img_cursor - IMAGE_HEADER_BYTES])
      e.req.kind = REQ_WRITE;
    e.res = step_image_port(e.req);
    pending_requests.push_back(e);
  endtask

  // tape file of n_bytes; size, load and exec words sit at their header offsets
  task automatic add_file(logic [15:0] size_w, int n_bytes, logic [15:0] load_w,
                          logic [15:0] exec_w);
    byte_t b;
    for (int i = 0; i < n_bytes; i++) begin
      case (i)
        OFS_SIZE:     b = size_w[7:0];
        OFS_SIZE + 1: b = size_w[15:8];
        OFS_LOAD:     b = load_w[7:0];
        OFS_LOAD + 1: b = load_w[15:8];
        OFS_EXEC:     b = exec_w[7:0];
        OFS_EXEC + 1: b = exec_w[15:8];
        default:      b = 8'($urandom_range(0, 255));
      endcase
      add_req(REQ_LOAD, b, i == n_bytes - 1, 17'($urandom_range(0, 17'h1FFFF)));
    end
  endtask

  // random walk over a loaded image
  task automatic add_ops(int n);
    int pick;
    logic [16:0] pos;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        add_req(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), '0);
      end else if (pick < 11) begin
        add_req(REQ_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), '0);
      end else if (pick < 15) begin
        if ($urandom_range(0, 9) == 0)
          pos = ($urandom_range(0, 1) == 0) ? 17'(img_total + $urandom_range(0, 3))
                                            : 17'($urandom_range(0, 17'h1FFFF));
        else
          pos = 17'($urandom_range(0, img_total - 1));
        add_req(REQ_SEEK, 8'($urandom_range(0, 255)), 1'b0, pos);
      end else if (pick < 19) begin
        add_req(REQ_SKIP, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        add_req(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 17'($urandom_range(0, 17'h1FFFF)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: requests go out in bursts of random length with random gaps.
  // --------------------------------------------------------------------------
  port_entry_t on_bus;
  int          gap_left = 0;
  int          burst_left = 1;

  always @(posedge clk) begin : request_driver
    logic show;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      show = in_tvalid;
      if (in_tvalid && in_tready) begin
        due_results.push_back(on_bus.res);
        show = 1'b0;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!show && gap_left > 0) begin
        gap_left--;
      end else if (!show && pending_requests.size() != 0) begin
        on_bus = pending_requests.pop_front();
        in_tdata <= {7'd0, on_bus.req.seek_pos, on_bus.req.data};
        in_tuser <= on_bus.req.kind;
        in_tlast <= on_bus.req.last;
        show = 1'b1;
      end
      in_tvalid <= show;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every result and stalls the output on its own pattern:
  // always ready, random stalls, or a periodic pattern from a tick counter.
  // --------------------------------------------------------------------------
  int mismatches = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s at %0t: expected %0d, got %0d", name, $realtime, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    image_result_t got;
    image_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_byte  = out_tdata[7:0];
        got.position   = out_tdata[24:8];
        got.image_size = out_tdata[41:25];
        got.status     = out_tuser;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result at %0t with no request owed", $realtime);
        end else begin
          want = due_results.pop_front();
          check_field("read_byte", int'(want.read_byte), int'(got.read_byte));
          check_field("status", int'(want.status), int'(got.status));
          check_field("position", int'(want.position), int'(got.position));
          check_field("image_size", int'(want.image_size), int'(got.image_size));
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 2) != 0);
        default: out_tready <= (stall_tick % 5 >= 2);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    int blen;
    int nbytes;
    logic [15:0] size_w;
    logic [2:0]  kind;
    clear_image();

    // requests before any load: all refused except the unknown kinds
    add_req(REQ_READ, 8'h00, 1'b0, '0);
    add_req(REQ_WRITE, 8'hFF, 1'b1, '0);
    add_req(REQ_SEEK, 8'h00, 1'b0, '0);
    add_req(REQ_SKIP, 8'h00, 1'b0, '0);
    add_req(3'd5, 8'hAA, 1'b0, 17'h1FFFF);
    add_req(3'd7, 8'h55, 1'b1, 17'h0AAAA);

    // file that ends inside its header: zero header, image of nine
    add_file(16'h1234, 24, 16'hFFFF, 16'h8001);
    add_req(REQ_READ, 8'h00, 1'b0, '0);
    add_req(REQ_SEEK, 8'h00, 1'b0, 17'd8);
    add_req(REQ_SEEK, 8'h00, 1'b0, 17'd9);
    add_req(REQ_WRITE, 8'hC3, 1'b0, '0);

    // header only, body promised but never sent
    add_file(16'd3, SOURCE_HEADER_BYTES, 16'hFFFF, 16'h0000);
    add_req(REQ_SEEK, 8'h00, 1'b0, 17'd11);
    add_req(REQ_READ, 8'h00, 1'b0, '0);

    // small full image, read all the way round past the wrap
    add_file(16'd4, SOURCE_HEADER_BYTES + 4, 16'h1200, 16'hFFFF);
    repeat (14) add_req(REQ_READ, 8'h00, 1'b0, '0);
    add_req(REQ_WRITE, 8'h00, 1'b0, '0);
    add_req(REQ_SEEK, 8'h00, 1'b0, 17'd12);
    add_req(REQ_SKIP, 8'h00, 1'b0, '0);

    // random part: files, some malformed, each followed by a walk over the image
    // while there is room for one, the rest loose requests of any kind
    while (pending_requests.size() < 650) begin
      if (650 - pending_requests.size() >= 220 && $urandom_range(0, 9) < 7) begin
        blen = $urandom_range(0, 48);
        nbytes = SOURCE_HEADER_BYTES + blen;
        case ($urandom_range(0, 5))
          0: size_w = 16'(blen + $urandom_range(1, 8));     // body cut short
          1: size_w = (blen > 0) ? 16'($urandom_range(0, blen - 1)) : 16'd0;
          2: begin                                          // ends in header
            size_w = 16'($urandom_range(0, 16'hFFFF));
            nbytes = $urandom_range(1, SOURCE_HEADER_BYTES - 1);
          end
          default: size_w = 16'(blen);
        endcase
        add_file(size_w, nbytes, 16'($urandom_range(0, 16'hFFFF)),
                 16'($urandom_range(0, 16'hFFFF)));
        add_ops(int'($urandom_range(5, 40)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          kind = 3'($urandom_range(0, 7));
          add_req(kind, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  17'($urandom_range(0, 17'h1FFFF)));
        end
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // hang guard, well above the slowest legal run
  initial begin : hang_guard
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
